[design/imgrm_pkg.sv]
// Shared types and constants for the input monitor gain ramp mixer.
`default_nettype none
package imgrm_pkg;

	localparam int DATA_W        = 32;
	localparam int LEN_W         = 11;
	localparam int MAX_BLOCK_LEN = 1024;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ECHO_ENABLE   = 2'd0,
		CFG_CHANNEL_MODE  = 2'd1,
		CFG_RENDER_STEREO = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		MODE_COMBINE  = 3'd0,
		MODE_LEFT     = 3'd1,
		MODE_RIGHT    = 3'd2,
		MODE_BALANCED = 3'd3,
		MODE_STEREO   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_DIV   = 3'd1,
		S_GAIN  = 3'd2,
		S_MUL_L = 3'd3,
		S_MUL_R = 3'd4,
		S_MIX   = 3'd5
	} state_t;

	// divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

[design/imgrm_div.sv]
// Bit-serial signed-by-unsigned divider for the ramp step, one quotient bit per cycle.
`default_nettype none
module imgrm_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0] dividend,
	input  wire logic        [imgrm_pkg::LEN_W-1:0]  divisor,
	output imgrm_pkg::div_stat_t                     stat,
	output logic signed      [imgrm_pkg::DATA_W-1:0] quotient
);
	import imgrm_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  dsr_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [LEN_W:0]    rem_sh;
	logic [LEN_W:0]    rem_sub;
	logic              ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[DATA_W-1]};
		ge      = rem_sh >= {1'b0, dsr_q};
		rem_sub = rem_sh - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// work on the magnitude, fix the sign at the end
			dvd_q <= dividend[DATA_W-1] ? -dividend : dividend;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], ge};
		end
	end

	assign quotient  = neg_q ? -dvd_q : dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

[design/imgrm_mul.sv]
// Shared signed multiplier with registered product, used once per channel.
`default_nettype none
module imgrm_mul (
	input  wire logic                                  clk,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]   a,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]   b,
	output logic signed      [2*imgrm_pkg::DATA_W-1:0] prod
);
	import imgrm_pkg::*;

	logic signed [2*DATA_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule
`default_nettype wire

[design/input_monitor_gain_ramp_mixer.sv]
// Input monitor gain ramp mixer: sequencer, gain state and mix output register.
//
// Input words arrive on in_valid/in_ready and carry one stereo input sample, one
// stereo mix sample and the ramp fields. Results leave on out_valid/out_ready,
// one result word per input word, in order. Registers are written through
// cfg_valid/cfg_ready (always ready) with cfg_index and cfg_data. The user must
// write them only while idle; the block does not enforce this.
//
// An input word goes from acceptance to out_valid through gain update, one
// multiplier pass per channel, then the mix add. A word with block_start set
// first runs the ramp step division, one quotient bit a cycle through the
// bit-serial divider. One word is processed at a time, paced by the shared
// multiplier and serial divider; the next is taken once the last is registered.
//
// The result register frees the input side: a new word is accepted while a
// result waits. If the receiver stalls, the next word halts at the mix step
// until the waiting result is taken. Reset clears gain and step to zero,
// echo off, channel mode left, stereo rendering on.
`default_nettype none
module input_monitor_gain_ramp_mixer (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic        [imgrm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [imgrm_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                                    in_valid,
	output logic                                         in_ready,
	input  wire logic                                    block_start,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     gain_start,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     gain_end,
	input  wire logic        [imgrm_pkg::LEN_W-1:0]      block_len,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     in_left,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     in_right,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     mix_in_left,
	input  wire logic signed [imgrm_pkg::DATA_W-1:0]     mix_in_right,
	output logic                                         out_valid,
	input  wire logic                                    out_ready,
	output logic signed      [imgrm_pkg::DATA_W-1:0]     mix_out_left,
	output logic signed      [imgrm_pkg::DATA_W-1:0]     mix_out_right
);
	import imgrm_pkg::*;

	state_t state_q, state_d;

	logic        echo_q;
	mode_t       mode_q;
	logic        stereo_q;

	logic                     blk_q;
	logic signed [DATA_W-1:0] start_q;
	logic signed [DATA_W-1:0] in_l_q;
	logic signed [DATA_W-1:0] in_r_q;
	logic signed [DATA_W-1:0] mix_l_q;
	logic signed [DATA_W-1:0] mix_r_q;

	logic signed [DATA_W-1:0] gain_now_q;
	logic signed [DATA_W-1:0] gain_step_q;
	logic signed [DATA_W-1:0] sl_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] out_l_q;
	logic signed [DATA_W-1:0] out_r_q;

	logic                     in_acc;
	logic                     out_free;
	logic                     div_start;
	logic                     mul_right;
	logic                     mix_load;
	div_stat_t                div_stat;
	logic signed [DATA_W-1:0] div_q;
	logic [LEN_W-1:0]         len_clamp;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [2*DATA_W-1:0] prod;
	logic signed [DATA_W-1:0] sr;
	logic signed [DATA_W-1:0] add_l;
	logic signed [DATA_W-1:0] add_r;
	logic signed [DATA_W-1:0] half_sum;
	logic signed [DATA_W-1:0] half_dif;
	mode_t                    mode_eff;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q   <= 1'b0;
			mode_q   <= MODE_LEFT;
			stereo_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ECHO_ENABLE:   echo_q   <= cfg_data[0];
				CFG_CHANNEL_MODE:  mode_q   <= mode_t'(cfg_data);
				CFG_RENDER_STEREO: stereo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_acc) state_d = block_start ? S_DIV : S_GAIN;
			S_DIV:   if (div_stat.done) state_d = S_GAIN;
			S_GAIN:  state_d = S_MUL_L;
			S_MUL_L: state_d = S_MUL_R;
			S_MUL_R: state_d = S_MIX;
			S_MIX:   if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_right = 1'b0;
		mix_load  = 1'b0;
		case (state_q)
			S_IDLE:  in_ready  = 1'b1;
			S_MUL_R: mul_right = 1'b1;
			S_MIX:   mix_load  = out_free;
			default: ;
		endcase
		if (state_q == S_IDLE && in_acc && block_start) begin
			div_start = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// capture the input word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_q   <= block_start;
			start_q <= gain_start;
			in_l_q  <= in_left;
			in_r_q  <= in_right;
			mix_l_q <= mix_in_left;
			mix_r_q <= mix_in_right;
		end
	end

	// zero length counts as one, long blocks saturate
	always_comb begin
		if (block_len == '0) begin
			len_clamp = LEN_W'(1);
		end else if (int'(block_len) > MAX_BLOCK_LEN) begin
			len_clamp = LEN_W'(MAX_BLOCK_LEN);
		end else begin
			len_clamp = block_len;
		end
	end

	imgrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (gain_end - gain_start),
		.divisor  (len_clamp),
		.stat     (div_stat),
		.quotient (div_q)
	);

	// gain state: load the ramp on block start, then advance by the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_now_q  <= '0;
			gain_step_q <= '0;
		end else if (state_q == S_GAIN) begin
			if (blk_q) begin
				gain_step_q <= div_q;
				gain_now_q  <= start_q + div_q;
			end else begin
				gain_now_q  <= gain_now_q + gain_step_q;
			end
		end
	end

	// keep the right operand through the mix step so the product holds on a stall
	assign mul_a = (state_q == S_MUL_L) ? in_l_q : in_r_q;

	imgrm_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (gain_now_q),
		.prod (prod)
	);

	// hold the left product while the right one is formed
	always_ff @(posedge clk) begin
		if (mul_right) begin
			sl_q <= {prod[2*DATA_W-3:DATA_W], 2'b00};
		end
	end

	assign sr       = {prod[2*DATA_W-3:DATA_W], 2'b00};
	assign half_sum = (sl_q >>> 1) + (sr >>> 1);
	assign half_dif = (sl_q >>> 1) - (sr >>> 1);

	always_comb begin
		mode_eff = mode_q;
		if (mode_q == MODE_STEREO && !stereo_q) begin
			mode_eff = MODE_COMBINE;
		end
		case (mode_eff)
			MODE_COMBINE: begin
				add_l = half_sum;
				add_r = half_sum;
			end
			MODE_LEFT: begin
				add_l = sl_q;
				add_r = sl_q;
			end
			MODE_RIGHT: begin
				add_l = sr;
				add_r = sr;
			end
			MODE_BALANCED: begin
				add_l = half_dif;
				add_r = half_dif;
			end
			default: begin
				add_l = sl_q;
				add_r = sr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (mix_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_load) begin
			out_l_q <= echo_q ? mix_l_q + add_l : mix_l_q;
			out_r_q <= echo_q ? mix_r_q + add_r : mix_r_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign mix_out_left  = out_l_q;
	assign mix_out_right = out_r_q;

`ifndef SYNTHESIS
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !div_stat.busy)
		else $error("input ready while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_plain_to_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !block_start) |=> state_q == S_GAIN)
		else $error("word without block start skipped gain update");

	a_step_only_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_GAIN) |=> $stable(gain_step_q))
		else $error("ramp step changed outside gain update");
`endif

endmodule
`default_nettype wire
